// ===== hw/rtl/msf_pkg.sv =====
// Shared types, codes and the sigmoid table for the MLP forward-pass block.
package msf_pkg;

    localparam int CFG_W   = 7;
    localparam int COUNT_W = 7;
    localparam int ACT_W   = 9;

    typedef enum logic [1:0] {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_PIXEL  = 2'd1,
        OP_RUN         = 2'd2
    } msf_op_t;

    typedef enum logic [1:0] {
        REG_INPUT_COUNT   = 2'd0,
        REG_HIDDEN_LAYERS = 2'd1,
        REG_HIDDEN_COUNT  = 2'd2,
        REG_OUTPUT_COUNT  = 2'd3
    } msf_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_WRITE,
        ST_OUT
    } msf_state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         layer_index;
        logic [5:0]         source_node;
        logic [5:0]         target_node;
        logic signed [15:0] weight_value;
        logic [7:0]         pixel_value;
    } msf_in_t;

    typedef struct packed {
        logic [5:0]       output_index;
        logic [ACT_W-1:0] output_value;
        logic             last_output;
    } msf_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic wt_we;
        logic px_we;
        logic issue;
        logic layer0;
        logic clear;
        logic act_we;
        logic out_load;
        logic last;
        logic bank;
    } msf_cmd_t;

    typedef struct packed {
        logic out_taken;
    } msf_status_t;

    // Positive half of the logistic curve in unsigned Q1.8, argument step 1/8
    localparam logic [ACT_W-1:0] SIG_HALF [65] = '{
        9'd128, 9'd136, 9'd144, 9'd152, 9'd159, 9'd167, 9'd174, 9'd181,
        9'd187, 9'd193, 9'd199, 9'd204, 9'd209, 9'd214, 9'd218, 9'd222,
        9'd225, 9'd229, 9'd232, 9'd234, 9'd237, 9'd239, 9'd241, 9'd242,
        9'd244, 9'd245, 9'd246, 9'd248, 9'd248, 9'd249, 9'd250, 9'd251,
        9'd251, 9'd252, 9'd252, 9'd253, 9'd253, 9'd254, 9'd254, 9'd254,
        9'd254, 9'd254, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255,
        9'd255, 9'd255, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256,
        9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256, 9'd256,
        9'd256
    };

endpackage

// ===== hw/rtl/msf_ram.sv =====
// Generic simple dual-port RAM with registered read.
module msf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/msf_ctrl.sv =====
// Run sequencer: configuration registers, loop counters and state machine.
module msf_ctrl
    import msf_pkg::*;
#(
    parameter int MAX_NODES  = 64,
    parameter int MAX_LAYERS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      opcode,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [CFG_W-1:0]                cfg_data,
    input  msf_status_t                     status,
    output msf_cmd_t                        cmd,
    output logic [$clog2(MAX_LAYERS)-1:0]   layer,
    output logic [$clog2((MAX_NODES < 64) ? MAX_NODES : 64)-1:0] src,
    output logic [$clog2((MAX_NODES < 64) ? MAX_NODES : 64)-1:0] node
);

    localparam int NODE_CAP = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam int IW       = $clog2(NODE_CAP);
    localparam int LW       = $clog2(MAX_LAYERS);
    localparam int HL_MAX   = MAX_LAYERS - 2;

    msf_state_t state_reg, state_next;

    logic [COUNT_W-1:0] in_cnt_reg, hid_cnt_reg, out_cnt_reg;
    logic [2:0]         hid_lay_reg;

    logic [LW-1:0] layer_reg, layer_next;
    logic [IW-1:0] src_reg, src_next;
    logic [IW-1:0] node_reg, node_next;
    logic          bank_reg, bank_next;

    logic [COUNT_W-1:0] n_in, n_hc, n_out, prev_n, next_n;
    logic [LW-1:0]      n_hl;
    logic               run_start, src_last, node_last, last_layer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= COUNT_W'(64);
            hid_lay_reg <= 3'd6;
            hid_cnt_reg <= COUNT_W'(6);
            out_cnt_reg <= COUNT_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INPUT_COUNT:   in_cnt_reg  <= cfg_data;
                REG_HIDDEN_LAYERS: hid_lay_reg <= cfg_data[2:0];
                REG_HIDDEN_COUNT:  hid_cnt_reg <= cfg_data;
                REG_OUTPUT_COUNT:  out_cnt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp counts at use
    always_comb
    begin
        n_in  = (in_cnt_reg == '0) ? COUNT_W'(1) :
                (32'(in_cnt_reg) > NODE_CAP) ? COUNT_W'(NODE_CAP) : in_cnt_reg;
        n_hc  = (hid_cnt_reg == '0) ? COUNT_W'(1) :
                (32'(hid_cnt_reg) > NODE_CAP) ? COUNT_W'(NODE_CAP) : hid_cnt_reg;
        n_out = (out_cnt_reg == '0) ? COUNT_W'(1) :
                (32'(out_cnt_reg) > NODE_CAP) ? COUNT_W'(NODE_CAP) : out_cnt_reg;
        n_hl  = (hid_lay_reg == '0) ? LW'(1) :
                (32'(hid_lay_reg) > HL_MAX) ? LW'(HL_MAX) : LW'(hid_lay_reg);
    end

    assign last_layer = (layer_reg == n_hl);
    assign prev_n     = (layer_reg == '0) ? n_in : n_hc;
    assign next_n     = last_layer ? n_out : n_hc;
    assign src_last   = (COUNT_W'(src_reg) + COUNT_W'(1)) == prev_n;
    assign node_last  = (COUNT_W'(node_reg) + COUNT_W'(1)) == next_n;
    assign run_start  = in_valid && in_ready && (opcode == OP_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            layer_reg <= '0;
            src_reg   <= '0;
            node_reg  <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            src_reg   <= src_next;
            node_reg  <= node_next;
            bank_reg  <= bank_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (run_start) state_next = ST_MAC;
            ST_MAC:    if (src_last) state_next = ST_DRAIN1;
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_WRITE;
            ST_WRITE:  state_next = last_layer ? ST_OUT : ST_MAC;
            ST_OUT:
            begin
                if (status.out_taken)
                begin
                    state_next = node_last ? ST_IDLE : ST_MAC;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        layer_next = layer_reg;
        src_next   = src_reg;
        node_next  = node_reg;
        bank_next  = bank_reg;
        case (state_reg)
            ST_IDLE:
            begin
                layer_next = '0;
                src_next   = '0;
                node_next  = '0;
                bank_next  = 1'b0;
            end
            ST_MAC:
            begin
                src_next = src_last ? '0 : src_reg + IW'(1);
            end
            ST_WRITE:
            begin
                // advance to the next node, or flip banks at the end of a layer
                if (!last_layer)
                begin
                    if (node_last)
                    begin
                        node_next  = '0;
                        layer_next = layer_reg + LW'(1);
                        bank_next  = ~bank_reg;
                    end
                    else
                    begin
                        node_next = node_reg + IW'(1);
                    end
                end
            end
            ST_OUT:
            begin
                if (status.out_taken && !node_last)
                begin
                    node_next = node_reg + IW'(1);
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd          = '0;
        cmd.wt_we    = in_valid && in_ready && (opcode == OP_LOAD_WEIGHT);
        cmd.px_we    = in_valid && in_ready && (opcode == OP_LOAD_PIXEL);
        cmd.issue    = (state_reg == ST_MAC);
        cmd.layer0   = (layer_reg == '0);
        cmd.clear    = (state_reg == ST_IDLE) || (state_reg == ST_WRITE);
        cmd.act_we   = (state_reg == ST_WRITE) && !last_layer;
        cmd.out_load = (state_reg == ST_WRITE) && last_layer;
        cmd.last     = node_last;
        cmd.bank     = bank_reg;
    end

    assign layer = layer_reg;
    assign src   = src_reg;
    assign node  = node_reg;

endmodule

// ===== hw/rtl/msf_datapath.sv =====
// Weight, pixel and activation stores, multiply-accumulate, sigmoid, result register.
module msf_datapath
    import msf_pkg::*;
#(
    parameter int MAX_NODES   = 64,
    parameter int MAX_LAYERS  = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  msf_in_t                         in_data,
    input  msf_cmd_t                        cmd,
    input  logic [$clog2(MAX_LAYERS)-1:0]   layer,
    input  logic [$clog2((MAX_NODES < 64) ? MAX_NODES : 64)-1:0] src,
    input  logic [$clog2((MAX_NODES < 64) ? MAX_NODES : 64)-1:0] node,
    output msf_status_t                     status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output msf_out_t                        out_data
);

    localparam int NODE_CAP = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam int IW       = $clog2(NODE_CAP);
    localparam int LW       = $clog2(MAX_LAYERS);
    localparam int NW       = $clog2(MAX_NODES);
    localparam int WAW      = LW + 2 * NW;
    localparam int PW       = WEIGHT_BITS + 18;
    localparam int ACC_W    = WEIGHT_BITS + 24;
    localparam logic signed [ACC_W-1:0] SUM_HI = ACC_W'((64'sd8 <<< 20) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SUM_LO = ACC_W'(-(64'sd8 <<< 20));

    // load side
    logic                   wt_ok;
    logic [WAW-1:0]         wt_waddr, wt_raddr;
    logic signed [31:0]     w_ext;
    logic [WEIGHT_BITS-1:0] wt_rdata;
    logic [7:0]             px_rdata;
    logic [ACT_W-1:0]       act_rdata, sig;

    logic                   rd_vld_reg, rd_l0_reg, prod_vld_reg;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [16:0]            act_op;
    logic signed [6:0]      k;
    logic [6:0]             kmag;

    logic     out_valid_reg;
    msf_out_t out_data_reg;

    assign wt_ok = (32'(in_data.layer_index) < MAX_LAYERS)
                && (32'(in_data.source_node) < MAX_NODES)
                && (32'(in_data.target_node) < MAX_NODES);
    assign wt_waddr = {LW'(in_data.layer_index), NW'(in_data.source_node),
                       NW'(in_data.target_node)};
    assign wt_raddr = {layer, NW'(src), NW'(node)};
    assign w_ext    = 32'(in_data.weight_value);

    msf_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << WAW)) u_weight_ram (
        .clk   (clk),
        .we    (cmd.wt_we && wt_ok),
        .waddr (wt_waddr),
        .wdata (w_ext[WEIGHT_BITS-1:0]),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    msf_ram #(.WIDTH(8), .DEPTH(64)) u_pixel_ram (
        .clk   (clk),
        .we    (cmd.px_we),
        .waddr (in_data.source_node),
        .wdata (in_data.pixel_value),
        .raddr (6'(src)),
        .rdata (px_rdata)
    );

    msf_ram #(.WIDTH(ACT_W), .DEPTH(2 << IW)) u_act_ram (
        .clk   (clk),
        .we    (cmd.act_we),
        .waddr ({~cmd.bank, node}),
        .wdata (sig),
        .raddr ({cmd.bank, src}),
        .rdata (act_rdata)
    );

    // layer zero takes the pixel as a Q8.8 activation
    assign act_op    = rd_l0_reg ? {1'b0, px_rdata, 8'h00} : 17'(act_rdata);
    assign prod_next = $signed({1'b0, act_op}) * $signed(wt_rdata);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.clear)
        begin
            acc_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= cmd.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_l0_reg <= cmd.layer0;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
    end

    // saturate to [-8, 8) and index the table in steps of 1/8
    always_comb
    begin
        if (acc_reg > SUM_HI)
        begin
            k = 7'sd63;
        end
        else if (acc_reg < SUM_LO)
        begin
            k = -7'sd64;
        end
        else
        begin
            k = acc_reg[23:17];
        end
        kmag = 7'(-k);
        if (!k[6])
        begin
            sig = SIG_HALF[k];
        end
        else
        begin
            sig = ACT_W'(256) - SIG_HALF[kmag];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.output_index <= 6'(node);
            out_data_reg.output_value <= sig;
            out_data_reg.last_output  <= cmd.last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_data         = out_data_reg;
    assign status.out_taken = out_valid_reg && out_ready;

endmodule

// ===== hw/rtl/mlp_sigmoid_forward_pass.sv =====
// Top level of the MLP forward-pass block with sigmoid activation.
// Loads: one weight or pixel transfer per cycle while idle, no result.
// Run: each node steps through its prev_n source reads (ST_MAC), then ST_DRAIN1 and
//   ST_DRAIN2, and the sigmoid write; each output node then waits until taken.
// Reset clears control and restores register defaults 64, 6, 6, 3; stores are
//   not cleared.
module mlp_sigmoid_forward_pass
    import msf_pkg::*;
#(
    parameter int MAX_NODES   = 64,
    parameter int MAX_LAYERS  = 8,
    parameter int WEIGHT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  msf_in_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output msf_out_t         out_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int NODE_CAP = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam int IW       = $clog2(NODE_CAP);
    localparam int LW       = $clog2(MAX_LAYERS);

    msf_cmd_t    cmd;
    msf_status_t status;
    logic [LW-1:0] layer;
    logic [IW-1:0] src, node;

    msf_ctrl #(.MAX_NODES(MAX_NODES), .MAX_LAYERS(MAX_LAYERS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (in_data.opcode),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd),
        .layer     (layer),
        .src       (src),
        .node      (node)
    );

    msf_datapath #(
        .MAX_NODES   (MAX_NODES),
        .MAX_LAYERS  (MAX_LAYERS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .layer     (layer),
        .src       (src),
        .node      (node),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== hw/rtl/msf_checker.sv =====
// Port-level checks for the MLP forward-pass block, bound to the top level.
module msf_checker
    import msf_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input msf_out_t out_data
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // no new item while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    // more results follow a non-final transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_output |=> !in_ready)
        else $error("run ended before last output");

    // an output value never exceeds 256
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.output_value <= 9'd256)
        else $error("output value out of range");

endmodule

bind mlp_sigmoid_forward_pass msf_checker u_msf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
